// File: design/wtfs_pkg.sv
// Shared widths, unit result structs and the reciprocal table for the
// three-fiber Watson signal block. No dependencies.
package wtfs_pkg;

    localparam int MAX_DIR_DEFAULT = 64;
    localparam int FIBER_DEFAULT   = 3;

    localparam int COMP_W     = 16;
    localparam int K_W        = 16;
    localparam int SQRT_IN_W  = 64;
    localparam int ROOT_W     = 32;
    localparam int DIV_NUM_W  = 48;
    localparam int DIV_DEN_W  = 32;
    localparam int DIV_Q_W    = 16;
    localparam int EXP_ARG_W  = 20;
    localparam int EXP_RES_W  = 17;
    localparam int RAW_W      = 18;
    localparam int SSUM_W     = 48;
    localparam int SIGNAL_W   = 16;
    localparam int IDX_W      = 6;
    localparam int ACTIVE_W   = 7;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_res_t;

    typedef struct packed {
        logic               done;
        logic               sat;
        logic [DIV_Q_W-1:0] quot;
    } div_res_t;

    typedef struct packed {
        logic                 done;
        logic [EXP_RES_W-1:0] value;
    } exp_res_t;

    // floor(2^32 / j) for the Taylor term divisors
    function automatic logic [32:0] recip(input logic [3:0] j);
        logic [32:0] r;
        case (j)
            4'd1:    r = 33'd4294967296;
            4'd2:    r = 33'd2147483648;
            4'd3:    r = 33'd1431655765;
            4'd4:    r = 33'd1073741824;
            4'd5:    r = 33'd858993459;
            4'd6:    r = 33'd715827882;
            4'd7:    r = 33'd613566756;
            4'd8:    r = 33'd536870912;
            4'd9:    r = 33'd477218588;
            4'd10:   r = 33'd429496729;
            4'd11:   r = 33'd390451572;
            4'd12:   r = 33'd357913941;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage

// File: design/wtfs_sqrt.sv
// Bit-pair iterative integer square root, 64-bit operand, 32-bit root.
// Depends on wtfs_pkg.
module wtfs_sqrt import wtfs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [SQRT_IN_W-1:0] operand,
    output sqrt_res_t            res
);

    logic [SQRT_IN_W-1:0] op_reg;
    logic [ROOT_W+1:0]    rem_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [4:0]           cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [ROOT_W+3:0] rem_sh;
    logic [ROOT_W+3:0] trial;
    logic              ge;

    always_comb begin
        rem_sh = {rem_reg, op_reg[SQRT_IN_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                op_reg   <= operand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= ge ? (ROOT_W+2)'(rem_sh - trial) : rem_sh[ROOT_W+1:0];
                root_reg <= {root_reg[ROOT_W-2:0], ge};
                op_reg   <= op_reg << 2;
                cnt_reg  <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.root = root_reg;

endmodule

// File: design/wtfs_div.sv
// Restoring divider, 48-bit numerator by 32-bit divisor, 16 quotient bits;
// flags quotients of 2^16 and more. Depends on wtfs_pkg.
module wtfs_div import wtfs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output div_res_t             res
);

    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_Q_W-1:0]   nsh_reg;
    logic [DIV_Q_W-1:0]   quot_reg;
    logic [3:0]           cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 sat_reg;

    logic [DIV_DEN_W:0] rem_sh;
    logic               ge;

    always_comb begin
        rem_sh = {rem_reg, nsh_reg[DIV_Q_W-1]};
        ge     = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                den_reg  <= den;
                rem_reg  <= num[DIV_NUM_W-1:DIV_Q_W];
                nsh_reg  <= num[DIV_Q_W-1:0];
                quot_reg <= '0;
                cnt_reg  <= '0;
                if (num >= {den, {DIV_Q_W{1'b0}}}) begin
                    sat_reg  <= 1'b1;
                    done_reg <= 1'b1;
                end else begin
                    sat_reg  <= 1'b0;
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                rem_reg  <= ge ? DIV_DEN_W'(rem_sh - {1'b0, den_reg})
                               : rem_sh[DIV_DEN_W-1:0];
                quot_reg <= {quot_reg[DIV_Q_W-2:0], ge};
                nsh_reg  <= nsh_reg << 1;
                cnt_reg  <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.sat  = sat_reg;
    assign res.quot = quot_reg;

endmodule

// File: design/wtfs_exp.sv
// Sequenced exp(-k*m^2) unit: 12-term Taylor series on x/16, then four
// squarings, result Q.16. Depends on wtfs_pkg (widths, reciprocal table).
module wtfs_exp import wtfs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [EXP_ARG_W-1:0] arg,
    input  logic [K_W-1:0]       kappa,
    output exp_res_t             res
);

    typedef enum logic [3:0] {
        EX_IDLE, EX_SQ, EX_MULK, EX_CHK, EX_TMUL, EX_TREC, EX_TCOR,
        EX_SQR, EX_SQRND, EX_FIN
    } ex_state_t;

    localparam logic [55:0] X_LIMIT = 56'd12 << 36;

    ex_state_t           state_reg;
    logic [EXP_ARG_W-1:0] arg_reg;
    logic [K_W-1:0]      k_reg;
    logic [39:0]         sq_reg;
    logic [55:0]         x_reg;
    logic [30:0]         t_reg;
    logic [31:0]         term_reg;
    logic signed [33:0]  sum_reg;
    logic [3:0]          j_reg;
    logic [62:0]         p_reg;
    logic [31:0]         v_reg;
    logic [64:0]         pr_reg;
    logic [31:0]         e_reg;
    logic [63:0]         e2_reg;
    logic [1:0]          cnt_reg;
    logic                done_reg;
    logic [EXP_RES_W-1:0] val_reg;

    logic [55:0]        t_full;
    logic [31:0]        v_next;
    logic [31:0]        q0;
    logic [35:0]        qj;
    logic [35:0]        r;
    logic [31:0]        q_next;
    logic signed [33:0] sum_next;
    logic [63:0]        rnd;
    logic [32:0]        fin;

    always_comb begin
        t_full = (x_reg + 56'd256) >> 9;
        v_next = p_reg[62:31];
        q0     = pr_reg[63:32];
        qj     = 36'(q0) * 36'(j_reg);
        r      = 36'(v_reg) - qj;
        if (r >= 36'({j_reg, 1'b0}))
            q_next = q0 + 32'd2;
        else if (r >= 36'(j_reg))
            q_next = q0 + 32'd1;
        else
            q_next = q0;
        if (j_reg[0])
            sum_next = sum_reg - $signed({2'b00, q_next});
        else
            sum_next = sum_reg + $signed({2'b00, q_next});
        rnd = e2_reg + 64'd1073741824;
        fin = 33'(e_reg) + 33'd16384;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EX_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                EX_IDLE: begin
                    if (start) begin
                        arg_reg   <= arg;
                        k_reg     <= kappa;
                        state_reg <= EX_SQ;
                    end
                end
                EX_SQ: begin
                    sq_reg    <= 40'(arg_reg) * 40'(arg_reg);
                    state_reg <= EX_MULK;
                end
                EX_MULK: begin
                    x_reg     <= 56'(sq_reg) * 56'(k_reg);
                    state_reg <= EX_CHK;
                end
                EX_CHK: begin
                    if (x_reg >= X_LIMIT) begin
                        val_reg   <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= EX_IDLE;
                    end else begin
                        t_reg     <= t_full[30:0];
                        term_reg  <= 32'h8000_0000;
                        sum_reg   <= 34'sh0_8000_0000;
                        j_reg     <= 4'd1;
                        state_reg <= EX_TMUL;
                    end
                end
                EX_TMUL: begin
                    p_reg     <= 63'(term_reg) * 63'(t_reg);
                    state_reg <= EX_TREC;
                end
                EX_TREC: begin
                    v_reg     <= v_next;
                    pr_reg    <= 65'(v_next) * 65'(recip(j_reg));
                    state_reg <= EX_TCOR;
                end
                EX_TCOR: begin
                    term_reg <= q_next;
                    sum_reg  <= sum_next;
                    if (j_reg == 4'd12) begin
                        e_reg     <= (sum_next > 34'sd0) ? sum_next[31:0] : 32'd0;
                        cnt_reg   <= '0;
                        state_reg <= EX_SQR;
                    end else begin
                        j_reg     <= j_reg + 4'd1;
                        state_reg <= EX_TMUL;
                    end
                end
                EX_SQR: begin
                    e2_reg    <= 64'(e_reg) * 64'(e_reg);
                    state_reg <= EX_SQRND;
                end
                EX_SQRND: begin
                    e_reg   <= rnd[62:31];
                    cnt_reg <= cnt_reg + 2'd1;
                    state_reg <= (cnt_reg == 2'd3) ? EX_FIN : EX_SQR;
                end
                EX_FIN: begin
                    val_reg   <= fin[31:15];
                    done_reg  <= 1'b1;
                    state_reg <= EX_IDLE;
                end
                default: state_reg <= EX_IDLE;
            endcase
        end
    end

    assign res.done  = done_reg;
    assign res.value = val_reg;

endmodule

// File: design/watson_three_fiber_signal.sv
// Three-fiber Watson signal block: request sequencer, direction and raw
// value memories, fiber registers. Depends on wtfs_pkg, wtfs_sqrt,
// wtfs_div and wtfs_exp.
//
// Usage: requests arrive on the s_ stream, kind in s_tuser. A direction
// load writes one entry of the direction memory as the request is accepted.
// A fiber load normalizes its vector through the shared root and divider
// units. An evaluate request emits one value per active direction on the
// m_ stream, m_tlast on the final one. Per direction, an evaluate forms a
// dot product and runs the iterative exponential unit for each fiber
// (Taylor terms over its multiply, reciprocal and correction states, then
// four squarings); then one root over the sum of squares, then the
// bit-serial divider for each output. One request is worked on at a time;
// s_tready is high only between requests.
// A stalled receiver holds the current output in the output register and
// pauses the output walk; the next request may be taken while the final
// output still waits. Reset clears the fiber table, the sum and the
// register (back to 64 directions); the direction memory holds whatever
// was last written and needs no clearing pass.
module watson_three_fiber_signal import wtfs_pkg::*; #(
    parameter int MAX_DIRECTIONS = MAX_DIR_DEFAULT,
    parameter int FIBER_COUNT    = FIBER_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [ACTIVE_W-1:0] cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // slot[5:0], comp_x[21:6], comp_y[37:22], comp_z[53:38],
    // concentration[69:54], zero pad [71:70]
    input  logic [71:0]         s_tdata,
    // kind[1:0]
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // signal[15:0], dir_index[21:16], zero pad [23:22]
    output logic [23:0]         m_tdata,
    output logic                m_tlast
);

    localparam int DIR_IW = (MAX_DIRECTIONS > 1) ? $clog2(MAX_DIRECTIONS) : 1;
    localparam int CNT_W  = $clog2(MAX_DIRECTIONS + 1);
    localparam int FIB_IW = (FIBER_COUNT > 1) ? $clog2(FIBER_COUNT) : 1;

    localparam logic [1:0] KIND_DIR   = 2'd0;
    localparam logic [1:0] KIND_FIBER = 2'd1;
    localparam logic [1:0] KIND_EVAL  = 2'd2;

    localparam logic [DIV_Q_W-1:0] FIB_LIMIT = 16'd16384;
    localparam logic [DIV_Q_W-1:0] SIG_LIMIT = 16'd32768;

    typedef enum logic [4:0] {
        ST_IDLE, ST_F_SQ, ST_F_ROOT_GO, ST_F_ROOT_WAIT, ST_F_DIV_GO, ST_F_DIV_WAIT,
        ST_E_RD, ST_E_DOT, ST_E_EXP_GO, ST_E_EXP_WAIT, ST_E_SQ, ST_E_ACC,
        ST_N_ROOT_GO, ST_N_ROOT_WAIT, ST_O_RD, ST_O_DIV_GO, ST_O_DIV_WAIT, ST_O_PUT
    } state_t;

    state_t state_reg;

    logic [3*COMP_W-1:0] dir_mem_reg [MAX_DIRECTIONS];
    logic [RAW_W-1:0]    raw_mem_reg [MAX_DIRECTIONS];
    logic [3*COMP_W-1:0] dir_rd_reg;
    logic [RAW_W-1:0]    raw_rd_reg;

    logic signed [COMP_W-1:0] fib_m_reg [FIBER_COUNT][3];
    logic [K_W-1:0]           fib_k_reg [FIBER_COUNT];

    logic [ACTIVE_W-1:0]      active_reg;
    logic signed [COMP_W-1:0] cur_c_reg [3];
    logic [K_W-1:0]           cur_k_reg;
    logic [FIB_IW-1:0]        cur_slot_reg;
    logic [31:0]              s_reg;
    logic [ROOT_W-1:0]        nrm_reg;
    logic [1:0]               cnt_reg;
    logic [FIB_IW-1:0]        f_reg;
    logic [DIR_IW-1:0]        i_reg;
    logic [CNT_W-1:0]         run_n_reg;
    logic signed [33:0]       dot_reg;
    logic [RAW_W-1:0]         raw_reg;
    logic [2*RAW_W-1:0]       sq_reg;
    logic [SSUM_W-1:0]        ssum_reg;
    logic [SIGNAL_W-1:0]      sig_reg;

    logic                m_tvalid_reg;
    logic [SIGNAL_W-1:0] m_sig_reg;
    logic [IDX_W-1:0]    m_idx_reg;
    logic                m_tlast_reg;

    // request fields
    logic [5:0]               in_slot;
    logic signed [COMP_W-1:0] in_c [3];
    logic [K_W-1:0]           in_k;
    logic                     in_acc;

    // unit hookups
    logic                 sqrt_start;
    logic [SQRT_IN_W-1:0] sqrt_op;
    sqrt_res_t            sqrt_res;
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    div_res_t             div_res;
    logic                 exp_start;
    logic [EXP_ARG_W-1:0] exp_arg;
    exp_res_t             exp_res;

    logic signed [COMP_W-1:0] dir_c;
    logic signed [COMP_W-1:0] fib_c;
    logic signed [31:0]       dot_prod;
    logic signed [31:0]       s_prod;
    logic [33:0]              dot_mag;
    logic [34:0]              dot_rnd;
    logic [COMP_W-1:0]        c_mag;
    logic [DIV_Q_W-1:0]       q_fib;
    logic [DIV_Q_W-1:0]       q_sig;
    logic [CNT_W-1:0]         n_eval;
    logic                     i_last;

    always_comb begin
        in_slot = s_tdata[5:0];
        in_c[0] = $signed(s_tdata[21:6]);
        in_c[1] = $signed(s_tdata[37:22]);
        in_c[2] = $signed(s_tdata[53:38]);
        in_k    = s_tdata[69:54];
        in_acc  = s_tvalid && s_tready;

        dir_c    = $signed(dir_rd_reg[COMP_W*cnt_reg +: COMP_W]);
        fib_c    = fib_m_reg[f_reg][cnt_reg];
        dot_prod = dir_c * fib_c;
        s_prod   = cur_c_reg[cnt_reg] * cur_c_reg[cnt_reg];
        dot_mag  = dot_reg[33] ? 34'(-dot_reg) : 34'(dot_reg);
        dot_rnd  = 35'(dot_mag) + 35'd8192;
        exp_arg  = dot_rnd[33:14];
        c_mag    = cur_c_reg[cnt_reg][COMP_W-1] ? (~cur_c_reg[cnt_reg] + 16'd1)
                                                : cur_c_reg[cnt_reg];

        if (nrm_reg == '0)
            q_fib = '0;
        else if (div_res.sat || (div_res.quot > FIB_LIMIT))
            q_fib = FIB_LIMIT;
        else
            q_fib = div_res.quot;

        if (nrm_reg == '0)
            q_sig = '0;
        else if (div_res.sat || (div_res.quot > SIG_LIMIT))
            q_sig = SIG_LIMIT;
        else
            q_sig = div_res.quot;

        n_eval = (32'(active_reg) > MAX_DIRECTIONS) ? CNT_W'(MAX_DIRECTIONS)
                                                    : CNT_W'(active_reg);
        i_last = ((CNT_W'(i_reg) + CNT_W'(1)) == run_n_reg);

        sqrt_start = (state_reg == ST_F_ROOT_GO) || (state_reg == ST_N_ROOT_GO);
        sqrt_op    = (state_reg == ST_F_ROOT_GO) ? SQRT_IN_W'({s_reg, 28'd0})
                                                 : {ssum_reg, 16'd0};
        div_start  = (state_reg == ST_F_DIV_GO) || (state_reg == ST_O_DIV_GO);
        if (state_reg == ST_F_DIV_GO)
            div_num = (DIV_NUM_W'(c_mag) << 28) + DIV_NUM_W'(nrm_reg >> 1);
        else
            div_num = (DIV_NUM_W'(raw_rd_reg) << 23) + DIV_NUM_W'(nrm_reg >> 1);
        exp_start  = (state_reg == ST_E_EXP_GO);
    end

    wtfs_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .operand (sqrt_op),
        .res     (sqrt_res)
    );

    wtfs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (nrm_reg),
        .res     (div_res)
    );

    wtfs_exp u_exp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (exp_start),
        .arg     (exp_arg),
        .kappa   (fib_k_reg[f_reg]),
        .res     (exp_res)
    );

    // memories
    always_ff @(posedge aclk) begin
        if (in_acc && (s_tuser == KIND_DIR) && (7'(in_slot) < 7'(MAX_DIRECTIONS)))
            dir_mem_reg[in_slot[DIR_IW-1:0]] <= s_tdata[53:6];
        if (state_reg == ST_E_RD)
            dir_rd_reg <= dir_mem_reg[i_reg];
        if (state_reg == ST_E_SQ)
            raw_mem_reg[i_reg] <= raw_reg;
        if (state_reg == ST_O_RD)
            raw_rd_reg <= raw_mem_reg[i_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            active_reg   <= ACTIVE_W'(64);
            ssum_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            for (int f = 0; f < FIBER_COUNT; f++) begin
                fib_k_reg[f] <= '0;
                for (int c = 0; c < 3; c++)
                    fib_m_reg[f][c] <= '0;
            end
        end else begin
            if (cfg_we)
                active_reg <= cfg_wdata;
            if (m_tvalid_reg && m_tready && (state_reg != ST_O_PUT))
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        case (s_tuser)
                            KIND_FIBER: begin
                                if (7'(in_slot) < 7'(FIBER_COUNT)) begin
                                    for (int c = 0; c < 3; c++)
                                        cur_c_reg[c] <= in_c[c];
                                    cur_k_reg    <= in_k;
                                    cur_slot_reg <= in_slot[FIB_IW-1:0];
                                    s_reg        <= '0;
                                    cnt_reg      <= '0;
                                    state_reg    <= ST_F_SQ;
                                end
                            end
                            KIND_EVAL: begin
                                ssum_reg  <= '0;
                                run_n_reg <= n_eval;
                                i_reg     <= '0;
                                if (n_eval != '0)
                                    state_reg <= ST_E_RD;
                            end
                            default: state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_F_SQ: begin
                    s_reg   <= s_reg + 32'(s_prod);
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd2)
                        state_reg <= ST_F_ROOT_GO;
                end
                ST_F_ROOT_GO: state_reg <= ST_F_ROOT_WAIT;
                ST_F_ROOT_WAIT: begin
                    if (sqrt_res.done) begin
                        nrm_reg   <= sqrt_res.root;
                        cnt_reg   <= '0;
                        state_reg <= ST_F_DIV_GO;
                    end
                end
                ST_F_DIV_GO: state_reg <= ST_F_DIV_WAIT;
                ST_F_DIV_WAIT: begin
                    if (div_res.done) begin
                        fib_m_reg[cur_slot_reg][cnt_reg] <=
                            cur_c_reg[cnt_reg][COMP_W-1] ? $signed(-q_fib) : $signed(q_fib);
                        if (cnt_reg == 2'd2) begin
                            fib_k_reg[cur_slot_reg] <= cur_k_reg;
                            state_reg <= ST_IDLE;
                        end else begin
                            cnt_reg   <= cnt_reg + 2'd1;
                            state_reg <= ST_F_DIV_GO;
                        end
                    end
                end
                ST_E_RD: begin
                    f_reg     <= '0;
                    cnt_reg   <= '0;
                    dot_reg   <= '0;
                    raw_reg   <= '0;
                    state_reg <= ST_E_DOT;
                end
                ST_E_DOT: begin
                    dot_reg <= dot_reg + 34'(dot_prod);
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd2)
                        state_reg <= ST_E_EXP_GO;
                end
                ST_E_EXP_GO: state_reg <= ST_E_EXP_WAIT;
                ST_E_EXP_WAIT: begin
                    if (exp_res.done) begin
                        raw_reg <= raw_reg + RAW_W'(exp_res.value);
                        if (f_reg == FIB_IW'(FIBER_COUNT - 1)) begin
                            state_reg <= ST_E_SQ;
                        end else begin
                            f_reg     <= f_reg + FIB_IW'(1);
                            dot_reg   <= '0;
                            cnt_reg   <= '0;
                            state_reg <= ST_E_DOT;
                        end
                    end
                end
                ST_E_SQ: begin
                    sq_reg    <= (2*RAW_W)'(raw_reg) * (2*RAW_W)'(raw_reg);
                    state_reg <= ST_E_ACC;
                end
                ST_E_ACC: begin
                    ssum_reg <= ssum_reg + SSUM_W'(sq_reg);
                    if (i_last) begin
                        state_reg <= ST_N_ROOT_GO;
                    end else begin
                        i_reg     <= i_reg + DIR_IW'(1);
                        state_reg <= ST_E_RD;
                    end
                end
                ST_N_ROOT_GO: state_reg <= ST_N_ROOT_WAIT;
                ST_N_ROOT_WAIT: begin
                    if (sqrt_res.done) begin
                        nrm_reg   <= sqrt_res.root;
                        i_reg     <= '0;
                        state_reg <= ST_O_RD;
                    end
                end
                ST_O_RD: state_reg <= ST_O_DIV_GO;
                ST_O_DIV_GO: state_reg <= ST_O_DIV_WAIT;
                ST_O_DIV_WAIT: begin
                    if (div_res.done) begin
                        sig_reg   <= q_sig;
                        state_reg <= ST_O_PUT;
                    end
                end
                ST_O_PUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_sig_reg    <= sig_reg;
                        m_idx_reg    <= IDX_W'(i_reg);
                        m_tlast_reg  <= i_last;
                        if (i_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            i_reg     <= i_reg + DIR_IW'(1);
                            state_reg <= ST_O_RD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_idx_reg, m_sig_reg};
    assign m_tlast  = m_tlast_reg;

    a_sig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_sig_reg <= SIG_LIMIT))
        else $error("output value above unity");

    a_acc_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_E_ACC) |=> (state_reg == ST_E_RD || state_reg == ST_N_ROOT_GO))
        else $error("direction walk left its loop");

    a_sqrt_done: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_res.done |-> (state_reg == ST_F_ROOT_WAIT || state_reg == ST_N_ROOT_WAIT))
        else $error("root result outside a wait state");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_F_DIV_WAIT || state_reg == ST_O_DIV_WAIT))
        else $error("quotient outside a wait state");

endmodule

// File: sim/wtfs_checker.sv
// Output checker for the three-fiber Watson signal block: mirrors the direction
// and fiber tables, predicts each evaluate run and compares the m_ stream.
// Depends on wtfs_pkg.
`timescale 1ns / 100ps

module wtfs_checker import wtfs_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [ACTIVE_W-1:0] cfg_wdata,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [71:0]         s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [23:0]         m_tdata,
    input  logic                m_tlast,
    output int                  mismatch_count,
    output int                  pending_count,
    output int                  signal_count
);
    localparam logic [1:0] KIND_DIR  = 2'd0;
    localparam logic [1:0] KIND_FIB  = 2'd1;
    localparam logic [1:0] KIND_EVAL = 2'd2;

    typedef struct packed {
        logic [15:0] signal;
        logic [5:0]  dir_index;
        logic        last;
    } signal_t;

    logic signed [15:0] dir_mem [64][3];
    logic signed [15:0] fib_m [3][3];
    logic [15:0]        fib_k [3];
    logic [6:0]         n_active;
    signal_t            expected_q [$];

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] watson_exp(input logic [63:0] x36);
        logic [63:0] t, term, e;
        longint      acc;
        if (x36 >= (64'd12 << 36)) return 0;
        t = (x36 + 256) >> 9;
        acc = longint'(1) << 31;
        term = 64'd1 << 31;
        for (int j = 1; j <= 12; j++) begin
            term = ((term * t) >> 31) / j;
            if (j % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        e = (acc > 0) ? 64'(acc) : 64'd0;
        for (int j = 0; j < 4; j++) e = (e * e + (64'd1 << 30)) >> 31;
        return 32'((e + (1 << 14)) >> 15);
    endfunction

    task automatic load_fiber(input logic [5:0] slot, input logic signed [15:0] c [3],
                              input logic [15:0] k);
        logic [63:0] s, nrm, a, q;
        s = 0;
        for (int i = 0; i < 3; i++) s = s + 64'(longint'(c[i]) * longint'(c[i]));
        nrm = isqrt(s << 28);
        for (int i = 0; i < 3; i++) begin
            a = (c[i] < 0) ? 64'(-longint'(c[i])) : 64'(longint'(c[i]));
            q = 0;
            if (nrm != 0) q = ((a << 28) + (nrm >> 1)) / nrm;
            if (q > 16384) q = 16384;
            fib_m[slot][i] = (c[i] < 0) ? -16'(q) : 16'(q);
        end
        fib_k[slot] = k;
    endtask

    task automatic predict_signals();
        int          n;
        logic [17:0] raw [64];
        logic [63:0] ssum, nrm, a, m14, q;
        logic [31:0] tot;
        longint      dot;
        signal_t     r;
        n = (n_active > 64) ? 64 : n_active;
        ssum = 0;
        for (int i = 0; i < n; i++) begin
            tot = 0;
            for (int f = 0; f < 3; f++) begin
                dot = 0;
                for (int j = 0; j < 3; j++)
                    dot = dot + longint'(dir_mem[i][j]) * longint'(fib_m[f][j]);
                a = (dot < 0) ? 64'(-dot) : 64'(dot);
                m14 = (a + (1 << 13)) >> 14;
                tot = tot + watson_exp(m14 * m14 * fib_k[f]);
            end
            raw[i] = tot[17:0];
            ssum = ssum + 64'(raw[i]) * 64'(raw[i]);
        end
        ssum = ssum & ((64'd1 << 48) - 1);
        nrm = isqrt(ssum << 16);
        for (int i = 0; i < n; i++) begin
            q = 0;
            if (nrm != 0) q = ((64'(raw[i]) << 23) + (nrm >> 1)) / nrm;
            if (q > 32768) q = 32768;
            r.signal = q[15:0];
            r.dir_index = 6'(i);
            r.last = (i == n - 1);
            expected_q.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        logic signed [15:0] c [3];
        signal_t got, exp_r;
        if (!aresetn) begin
            for (int f = 0; f < 3; f++) begin
                fib_k[f] = 0;
                for (int j = 0; j < 3; j++) fib_m[f][j] = 0;
            end
            n_active = 64;
            mismatch_count = 0;
            signal_count = 0;
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.signal = m_tdata[15:0];
                got.dir_index = m_tdata[21:16];
                got.last = m_tlast;
                signal_count++;
                if (expected_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected signal %h idx %0d last %b",
                                 got.signal, got.dir_index, got.last);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("signal mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     exp_r.signal, exp_r.dir_index, exp_r.last,
                                     got.signal, got.dir_index, got.last);
                    end
                end
            end
            if (cfg_we) n_active = cfg_wdata;
            if (s_tvalid && s_tready) begin
                c[0] = s_tdata[21:6];
                c[1] = s_tdata[37:22];
                c[2] = s_tdata[53:38];
                case (s_tuser)
                    KIND_DIR: begin
                        dir_mem[s_tdata[5:0]] = c;
                    end
                    KIND_FIB: begin
                        if (s_tdata[5:0] < 3) load_fiber(s_tdata[5:0], c, s_tdata[69:54]);
                    end
                    KIND_EVAL: begin
                        predict_signals();
                    end
                    default: ;
                endcase
            end
        end
        pending_count = expected_q.size();
    end
endmodule

// File: sim/tb_top.sv
// Stimulus and verdict for the three-fiber Watson signal block: loads, evaluates and
// config phases with random idling. Depends on the block, wtfs_pkg, wtfs_checker.
`timescale 1ns / 100ps

module tb_top import wtfs_pkg::*;;
    localparam logic [1:0] KIND_DIR  = 2'd0;
    localparam logic [1:0] KIND_FIB  = 2'd1;
    localparam logic [1:0] KIND_EVAL = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;

    logic                aclk = 0;
    logic                aresetn = 0;
    logic                cfg_we = 0;
    logic [ACTIVE_W-1:0] cfg_wdata = 0;
    logic                s_tvalid = 0;
    logic                s_tready;
    logic [71:0]         s_tdata = 0;
    logic [1:0]          s_tuser = 0;
    logic                m_tvalid;
    logic                m_tready = 0;
    logic [23:0]         m_tdata;
    logic                m_tlast;
    int                  mismatch_count, pending_count, signal_count;
    int                  send_idle = 0, recv_idle = 0;
    int                  cycles = 0, requests = 0, evals = 0;

    always #6 aclk = ~aclk;

    watson_three_fiber_signal uut (.*);
    wtfs_checker chk (.*);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_idle);

    task automatic send(input logic [1:0] kind, input logic [5:0] slot,
                        input logic [15:0] x, input logic [15:0] y,
                        input logic [15:0] z, input logic [15:0] k);
        while ($urandom_range(99) < send_idle) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = kind;
        s_tdata = {2'b00, k, z, y, x, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid = 1'b0;
        requests++;
        if (kind == KIND_EVAL) evals++;
    endtask

    task automatic drain();
        while (pending_count != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic write_active(input logic [6:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    function automatic logic [15:0] rcomp();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(32767)) - 16384);
            default: return 16'(int'($urandom_range(8192)) - 4096 + 16384);
        endcase
    endfunction

    task automatic random_request();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            send(KIND_DIR, 6'($urandom_range(63)), rcomp(), rcomp(), rcomp(), 16'($urandom));
        else if (r < 60)
            send(KIND_FIB, 6'($urandom_range(3)), rcomp(), rcomp(), rcomp(),
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2048)));
        else if (r < 95)
            send(KIND_EVAL, 6'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom));
        else
            send(KIND_NONE, 6'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom));
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);
        // every direction gets written so evaluates never touch unwritten entries
        for (int i = 0; i < 64; i++)
            send(KIND_DIR, 6'(i), 16'(int'($urandom_range(32767)) - 16384),
                 16'(int'($urandom_range(32767)) - 16384), 16'($urandom), 16'd0);
        send(KIND_EVAL, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send(KIND_FIB, 6'd0, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF);
        send(KIND_FIB, 6'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0100);
        send(KIND_FIB, 6'd2, 16'h4000, 16'h0001, 16'hC000, 16'h0000);
        send(KIND_FIB, 6'd5, 16'h1234, 16'h1234, 16'h1234, 16'h1234);
        send(KIND_DIR, 6'd0, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd0);
        send(KIND_NONE, 6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send(KIND_EVAL, 6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_active(7'd1);
        send(KIND_EVAL, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        write_active(7'd0);
        send(KIND_EVAL, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        write_active(7'd127);
        send(KIND_FIB, 6'd1, 16'h0000, 16'h4000, 16'h0000, 16'h0800);
        send(KIND_EVAL, 6'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 34 : (phase == 1) ? 70 : 0;
            recv_idle = (phase == 0) ? 70 : (phase == 1) ? 34 : 0;
            write_active(7'($urandom_range(1, 8)));
            for (int i = 0; i < 110; i++) begin
                if (i == 55) drain();
                random_request();
            end
            write_active((phase == 2) ? 7'd64 : 7'($urandom_range(1, 64)));
            for (int i = 0; i < 3; i++) random_request();
        end
        drain();
        $display("Covered %0d requests with %0d evaluates, %0d signals checked",
                 requests, evals, signal_count);
        $display("Direction counts 0, 1, 64 and saturated, zero fibers, both idling mixes");
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
